// ===== rtl/vsfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vsfe_pkg;

    typedef logic [2:0] face_t;
    typedef logic [2:0] cfg_idx_t;
    typedef logic [2:0] corner_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_INNER_VOLUME = 3'd0;
    localparam cfg_idx_t CFG_SIZE_X       = 3'd1;
    localparam cfg_idx_t CFG_SIZE_Y       = 3'd2;
    localparam cfg_idx_t CFG_SIZE_Z       = 3'd3;
    localparam cfg_idx_t CFG_ORIGIN_X     = 3'd4;
    localparam cfg_idx_t CFG_ORIGIN_Y     = 3'd5;
    localparam cfg_idx_t CFG_ORIGIN_Z     = 3'd6;
    localparam cfg_idx_t CFG_CELL_EDGE    = 3'd7;

    // action codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROCESS = 1'b1;

    // corner masks by face, triangle, vertex: bit0 +x, bit1 +y, bit2 +z
    localparam corner_t CORNER_TAB [6][2][3] = '{
        '{'{3'd0, 3'd6, 3'd2}, '{3'd0, 3'd4, 3'd6}},
        '{'{3'd1, 3'd3, 3'd7}, '{3'd1, 3'd7, 3'd5}},
        '{'{3'd0, 3'd1, 3'd5}, '{3'd0, 3'd5, 3'd4}},
        '{'{3'd2, 3'd7, 3'd3}, '{3'd2, 3'd6, 3'd7}},
        '{'{3'd0, 3'd2, 3'd1}, '{3'd3, 3'd1, 3'd2}},
        '{'{3'd4, 3'd5, 3'd6}, '{3'd7, 3'd6, 3'd5}}
    };

endpackage

`default_nettype wire

// ===== rtl/vsfe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vsfe_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 131072
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/voxel_surface_face_extractor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Contents
// s_*       in         s_valid / s_ready    one cell load or process command
// m_*       out        m_valid / m_ready    one triangle: face, three vertices, last
// cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// After reset the grid store is swept to zero, one cell a cycle:
// all MAX_X*MAX_Y*MAX_Z cells (131072 by default); s_ready stays low meanwhile.
// Load: the cell is written in the LOAD state, then the unit returns to idle; a cell out of range is dropped.
// Process: 9 read steps (center, six neighbors, shared multiply-add alongside), then, for a solid
// cell with open faces, one triangle per cycle while m_ready is high, two per open face.
// A stalled m_ready holds the output register and pauses triangle generation.
module voxel_surface_face_extractor_unit #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_valid,
    output      logic                     s_ready,
    input  wire logic                     s_action,
    input  wire logic [5:0]               s_cell_x,
    input  wire logic [5:0]               s_cell_y,
    input  wire logic [4:0]               s_cell_z,
    input  wire logic [1:0]               s_cell_value,

    output      logic                     m_valid,
    input  wire logic                     m_ready,
    output      vsfe_pkg::face_t          m_face,
    output      logic signed [31:0]       m_v0_x,
    output      logic signed [31:0]       m_v0_y,
    output      logic signed [31:0]       m_v0_z,
    output      logic signed [31:0]       m_v1_x,
    output      logic signed [31:0]       m_v1_y,
    output      logic signed [31:0]       m_v1_z,
    output      logic signed [31:0]       m_v2_x,
    output      logic signed [31:0]       m_v2_y,
    output      logic signed [31:0]       m_v2_z,
    output      logic                     m_last,

    input  wire logic                     cfg_valid,
    output      logic                     cfg_ready,
    input  wire vsfe_pkg::cfg_idx_t       cfg_index,
    input  wire logic [31:0]              cfg_data
);

    import vsfe_pkg::*;

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg;
    logic [3:0]         step_reg;
    logic               solid_reg;
    logic [5:0]         open_reg;
    logic               tri_reg;

    logic               inner_volume_reg;
    logic [6:0]         size_x_reg, size_y_reg;
    logic [5:0]         size_z_reg;
    logic signed [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [30:0]        cell_edge_reg;

    logic [5:0]         pos_x_reg, pos_y_reg;
    logic [4:0]         pos_z_reg;
    logic [1:0]         val_reg;
    logic [37:0]        prod_reg;
    logic signed [31:0] crd_x0_reg, crd_x1_reg, crd_y0_reg, crd_y1_reg;
    logic signed [31:0] crd_z0_reg, crd_z1_reg;

    logic               m_valid_reg;
    face_t              m_face_reg;
    logic signed [31:0] vx_reg [3];
    logic signed [31:0] vy_reg [3];
    logic signed [31:0] vz_reg [3];
    logic               m_last_reg;

    logic [6:0]         lim_x, lim_y;
    logic [5:0]         lim_z;
    logic               in_accept, in_range;
    logic [1:0]         solid_code;
    logic [5:0]         bnd;
    logic [5:0]         nx, ny;
    logic [4:0]         nz;
    logic [AW-1:0]      cell_addr;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [1:0]         ram_wr_data, ram_rd_data;
    logic [2:0]         open_idx;
    logic               mul_issue, mul_done;
    logic [6:0]         mul_idx;
    logic [2:0]         wr_op;
    logic signed [31:0] sum_org;
    logic signed [39:0] sum;
    logic signed [31:0] sat_val;
    face_t              cur_face;
    logic               emit_load, last_tri;
    corner_t            corner [3];
    logic signed [31:0] vx_next [3];
    logic signed [31:0] vy_next [3];
    logic signed [31:0] vz_next [3];

    // sizes above the store's dimension fold to the dimension
    assign lim_x = (32'(size_x_reg) > MAX_X) ? 7'(MAX_X) : size_x_reg;
    assign lim_y = (32'(size_y_reg) > MAX_Y) ? 7'(MAX_Y) : size_y_reg;
    assign lim_z = (32'(size_z_reg) > MAX_Z) ? 6'(MAX_Z) : size_z_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign in_range  = ({1'b0, s_cell_x} < lim_x) && ({1'b0, s_cell_y} < lim_y)
                    && ({1'b0, s_cell_z} < lim_z);
    assign cfg_ready = 1'b1;

    assign solid_code = {1'b0, ~inner_volume_reg};

    assign bnd[0] = (pos_x_reg == 6'd0);
    assign bnd[1] = ((7'(pos_x_reg) + 7'd1) >= lim_x);
    assign bnd[2] = (pos_y_reg == 6'd0);
    assign bnd[3] = ((7'(pos_y_reg) + 7'd1) >= lim_y);
    assign bnd[4] = (pos_z_reg == 5'd0);
    assign bnd[5] = ((6'(pos_z_reg) + 6'd1) >= lim_z);

    // read step 0 is the center, steps 1..6 the neighbors -x,+x,-y,+y,-z,+z;
    // on the grid edge the center is re-read and its data ignored
    always_comb begin
        nx = pos_x_reg;
        ny = pos_y_reg;
        nz = pos_z_reg;
        if (state_reg == ST_READ) begin
            case (step_reg)
                4'd1: if (!bnd[0]) nx = pos_x_reg - 6'd1;
                4'd2: if (!bnd[1]) nx = pos_x_reg + 6'd1;
                4'd3: if (!bnd[2]) ny = pos_y_reg - 6'd1;
                4'd4: if (!bnd[3]) ny = pos_y_reg + 6'd1;
                4'd5: if (!bnd[4]) nz = pos_z_reg - 5'd1;
                4'd6: if (!bnd[5]) nz = pos_z_reg + 5'd1;
                default: ;
            endcase
        end
    end

    assign cell_addr = AW'((32'(nz) * MAX_Y + 32'(ny)) * MAX_X + 32'(nx));

    assign ram_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_LOAD);
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : cell_addr;
    assign ram_wr_data = (state_reg == ST_CLEAR) ? 2'd0 : val_reg;

    vsfe_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (cell_addr),
        .rd_data (ram_rd_data)
    );

    // read data comes from a registered RAM read: face f lands at step f+2
    assign open_idx = 3'(step_reg - 4'd2);

    // shared multiply-add: op j = 2*axis + (upper corner), issued at step j,
    // summed and saturated at step j+1
    assign mul_issue = (state_reg == ST_READ) && (step_reg <= 4'd5);
    assign mul_done  = (state_reg == ST_READ) && (step_reg >= 4'd1) && (step_reg <= 4'd6);
    assign wr_op     = 3'(step_reg - 4'd1);

    always_comb begin
        case (step_reg[2:1])
            2'd0:    mul_idx = {1'b0, pos_x_reg} + 7'(step_reg[0]);
            2'd1:    mul_idx = {1'b0, pos_y_reg} + 7'(step_reg[0]);
            default: mul_idx = {2'b00, pos_z_reg} + 7'(step_reg[0]);
        endcase
        case (wr_op[2:1])
            2'd0:    sum_org = origin_x_reg;
            2'd1:    sum_org = origin_y_reg;
            default: sum_org = origin_z_reg;
        endcase
    end

    assign sum = $signed({{8{sum_org[31]}}, sum_org}) + $signed({2'b00, prod_reg});
    // in range when the top nine bits agree
    assign sat_val = (sum[39:31] == {9{sum[39]}}) ? sum[31:0]
                   : (sum[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    always_comb begin
        cur_face = 3'd0;
        for (int i = 5; i >= 0; i--) begin
            if (open_reg[i]) cur_face = 3'(i);
        end
    end

    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign last_tri  = tri_reg && ((open_reg & ~(6'b000001 << cur_face)) == 6'b000000);

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            corner[v]  = CORNER_TAB[cur_face][tri_reg][v];
            vx_next[v] = corner[v][0] ? crd_x1_reg : crd_x0_reg;
            vy_next[v] = corner[v][1] ? crd_y1_reg : crd_y0_reg;
            vz_next[v] = corner[v][2] ? crd_z1_reg : crd_z0_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_addr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (in_accept && in_range) begin
                    state_next = (s_action == ACT_PROCESS) ? ST_READ : ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_IDLE;
            ST_READ: begin
                if (step_reg == 4'd8) begin
                    state_next = (solid_reg && (open_reg != 6'd0)) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: if (emit_load && last_tri) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            step_reg         <= 4'd0;
            solid_reg        <= 1'b0;
            open_reg         <= 6'd0;
            tri_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
            inner_volume_reg <= 1'b0;
            size_x_reg       <= 7'd64;
            size_y_reg       <= 7'd64;
            size_z_reg       <= 6'd32;
            origin_x_reg     <= 32'sd0;
            origin_y_reg     <= 32'sd0;
            origin_z_reg     <= 32'sd0;
            cell_edge_reg    <= 31'd65536;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end

            if (in_accept) begin
                step_reg <= 4'd0;
                open_reg <= 6'd0;
                tri_reg  <= 1'b0;
            end

            if (state_reg == ST_READ) begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd1) begin
                    solid_reg <= (ram_rd_data == solid_code);
                end
                if ((step_reg >= 4'd2) && (step_reg <= 4'd7)) begin
                    open_reg[open_idx] <= bnd[open_idx] || (ram_rd_data != solid_code);
                end
            end

            if (emit_load) begin
                tri_reg <= ~tri_reg;
                if (tri_reg) begin
                    open_reg[cur_face] <= 1'b0;
                end
            end

            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_INNER_VOLUME: inner_volume_reg <= cfg_data[0];
                    CFG_SIZE_X:       size_x_reg       <= cfg_data[6:0];
                    CFG_SIZE_Y:       size_y_reg       <= cfg_data[6:0];
                    CFG_SIZE_Z:       size_z_reg       <= cfg_data[5:0];
                    CFG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                    CFG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                    CFG_ORIGIN_Z:     origin_z_reg     <= cfg_data;
                    CFG_CELL_EDGE:    cell_edge_reg    <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pos_x_reg <= s_cell_x;
            pos_y_reg <= s_cell_y;
            pos_z_reg <= s_cell_z;
            val_reg   <= s_cell_value;
        end
        if (mul_issue) begin
            prod_reg <= 38'(mul_idx) * 38'(cell_edge_reg);
        end
        if (mul_done) begin
            case (wr_op)
                3'd0:    crd_x0_reg <= sat_val;
                3'd1:    crd_x1_reg <= sat_val;
                3'd2:    crd_y0_reg <= sat_val;
                3'd3:    crd_y1_reg <= sat_val;
                3'd4:    crd_z0_reg <= sat_val;
                default: crd_z1_reg <= sat_val;
            endcase
        end
        if (emit_load) begin
            m_face_reg <= cur_face;
            m_last_reg <= last_tri;
            for (int v = 0; v < 3; v++) begin
                vx_reg[v] <= vx_next[v];
                vy_reg[v] <= vy_next[v];
                vz_reg[v] <= vz_next[v];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_face  = m_face_reg;
    assign m_v0_x  = vx_reg[0];
    assign m_v0_y  = vy_reg[0];
    assign m_v0_z  = vz_reg[0];
    assign m_v1_x  = vx_reg[1];
    assign m_v1_y  = vy_reg[1];
    assign m_v1_z  = vz_reg[1];
    assign m_v2_x  = vx_reg[2];
    assign m_v2_y  = vy_reg[2];
    assign m_v2_z  = vz_reg[2];
    assign m_last  = m_last_reg;

    // a cell out of range is dropped in its accept cycle and leaves s_ready high
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && in_range) |=> !s_ready)
        else $error("second transaction taken while one is in flight");

    a_emit_has_face: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (open_reg != 6'd0))
        else $error("triangle generation with no open face");

    a_pairs_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !tri_reg)
        else $error("face left with one triangle");

    a_face_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_face_reg <= 3'd5))
        else $error("bad face code on output");

endmodule

`default_nettype wire
